/* hw/rtl/pstc_pkg.sv */
// Package for the pressure sensor temperature compensation core.
// Field widths, register codes and the queue entry and coefficient types.
// Depends on nothing; every other file imports it.
`default_nettype none

package pstc_pkg;

	localparam int RAW_W     = 16;
	localparam int COEF_W    = 16;
	localparam int DIFF_W    = 17;
	localparam int PROD_W    = 34;
	localparam int X1_W      = 18;
	localparam int DVS_W     = 19;
	localparam int DMAG_W    = 18;
	localparam int MCMAG_W   = 16;
	localparam int NUM_W     = 27;
	localparam int X2_W      = 28;
	localparam int SUM_W     = 29;
	localparam int TEMP_W    = 24;

	localparam int SHIFT_X1  = 15;
	localparam int SHIFT_MC  = 11;
	localparam int ROUND_ADD = 8;
	localparam int SHIFT_OUT = 4;

	// quotient bits resolved per divider stage
	localparam int DIV_STEP   = 3;
	localparam int DIV_STAGES = NUM_W / DIV_STEP;

	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_C5 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C6 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MC = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MD = 4'd3;

	typedef struct packed {
		logic        [COEF_W-1:0] c5;
		logic        [COEF_W-1:0] c6;
		logic signed [COEF_W-1:0] mc;
		logic signed [COEF_W-1:0] md;
	} coef_t;

	typedef struct packed {
		logic signed [X1_W-1:0]  x1;
		logic signed [DVS_W-1:0] dvs;
		logic                    zero;
	} entry_t;

endpackage

`default_nettype wire

/* hw/rtl/pstc_ifs.sv */
// Channel interfaces of the compensation core: samples, results, register writes.
// Each carries valid, ready and its payload; depends on pstc_pkg.
`default_nettype none

interface pstc_sample_if;
	import pstc_pkg::*;
	logic              valid;
	logic              ready;
	logic [RAW_W-1:0]  raw_temp;
	modport source (output valid, output raw_temp, input ready);
	modport sink   (input valid, input raw_temp, output ready);
endinterface

interface pstc_result_if;
	import pstc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temp_tenths;
	logic                     div_zero;
	modport source (output valid, output temp_tenths, output div_zero, input ready);
	modport sink   (input valid, input temp_tenths, input div_zero, output ready);
endinterface

interface pstc_cfg_if;
	import pstc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COEF_W-1:0]    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pstc_front.sv */
// Front end: accepts raw samples, forms x1 and the divisor, flags a zero divisor.
// Three stall-together stages feeding the queue; depends on pstc_pkg and pstc_ifs.
`default_nettype none

module pstc_front
	import pstc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire coef_t     coef,
	pstc_sample_if.sink    sample,
	output logic           push_valid,
	input  wire logic      push_ready,
	output entry_t         push_data
);

	logic                     v_s1, v_s2, v_s3;
	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [PROD_W-1:0] prod_s2;
	entry_t                   ent_s3;
	logic                     adv;
	logic signed [X1_W-1:0]   x1_w;
	logic signed [DVS_W-1:0]  dvs_w;

	// hold the whole pipe while the last stage waits on the queue
	assign adv          = !v_s3 || push_ready;
	assign sample.ready = adv;

	// dropping the low bits of a two's complement value floors it
	assign x1_w  = prod_s2[SHIFT_X1 +: X1_W];
	assign dvs_w = {x1_w[X1_W-1], x1_w} + {{(DVS_W-COEF_W){coef.md[COEF_W-1]}}, coef.md};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= sample.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s1     <= $signed({1'b0, sample.raw_temp}) - $signed({1'b0, coef.c6});
			prod_s2     <= diff_s1 * $signed({1'b0, coef.c5});
			ent_s3.x1   <= x1_w;
			ent_s3.dvs  <= dvs_w;
			ent_s3.zero <= (dvs_w == '0);
		end
	end

	assign push_valid = v_s3;
	assign push_data  = ent_s3;

	a_hold_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !push_ready) |=> (v_s3 && $stable(ent_s3)))
		else $error("front stage changed while the queue was full");

endmodule

`default_nettype wire

/* hw/rtl/pstc_fifo.sv */
// Short queue between front and back end; registers, head read combinationally.
// Depends on pstc_pkg for the entry type.
`default_nettype none

module pstc_fifo
	import pstc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push_valid,
	output logic        push_ready,
	input  wire entry_t push_data,
	output logic        pop_valid,
	input  wire logic   pop_ready,
	output entry_t      pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	entry_t          mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            push, pop;

	assign push_ready = (cnt_q != FULL);
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL)
		else $error("queue count beyond depth");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count missed a request");

endmodule

`default_nettype wire

/* hw/rtl/pstc_back.sv */
// Back end: pipelined restoring divider for x2, then b5 and the rounded result.
// Stalls as a whole on the output register; depends on pstc_pkg and pstc_ifs.
`default_nettype none

module pstc_back
	import pstc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire coef_t     coef,
	input  wire logic      pop_valid,
	output logic           pop_ready,
	input  wire entry_t    pop_data,
	pstc_result_if.source  result
);

	localparam int NS = DIV_STAGES;

	typedef struct packed {
		logic [DMAG_W-1:0] rem;
		logic [NUM_W-1:0]  nq;
	} div_t;

	function automatic div_t div_steps(div_t cur, logic [DMAG_W-1:0] dvs);
		div_t            nxt;
		logic [DMAG_W:0] trial;
		nxt = cur;
		for (int i = 0; i < DIV_STEP; i++) begin
			trial  = {nxt.rem, nxt.nq[NUM_W-1]};
			nxt.nq = {nxt.nq[NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs}) begin
				trial     = trial - {1'b0, dvs};
				nxt.nq[0] = 1'b1;
			end
			nxt.rem = trial[DMAG_W-1:0];
		end
		return nxt;
	endfunction

	logic                      en;
	logic [NS:0]               v_d;
	div_t                      dv_d   [NS+1];
	logic [DMAG_W-1:0]         dmag_d [NS];
	logic signed [X1_W-1:0]    x1_d   [NS+1];
	logic [NS:0]               neg_d;
	logic [NS:0]               zero_d;

	logic                      v_f;
	logic signed [X2_W-1:0]    x2_f;
	logic signed [X1_W-1:0]    x1_f;
	logic                      zero_f;

	logic                      valid_q;
	logic signed [TEMP_W-1:0]  temp_q;
	logic                      dz_q;

	logic signed [DVS_W-1:0]   dneg_w;
	logic [MCMAG_W-1:0]        mcmag_w;
	logic signed [COEF_W:0]    mcneg_w;
	logic signed [SUM_W-1:0]   sum_w;

	// advance everything unless a result waits at the output
	assign en        = !valid_q || result.ready;
	assign pop_ready = en;

	assign dneg_w  = -pop_data.dvs;
	assign mcneg_w = -{coef.mc[COEF_W-1], coef.mc};
	assign mcmag_w = coef.mc[COEF_W-1] ? mcneg_w[MCMAG_W-1:0] : coef.mc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d     <= '0;
			v_f     <= 1'b0;
			valid_q <= 1'b0;
		end else if (en) begin
			v_d     <= {v_d[NS-1:0], pop_valid};
			v_f     <= v_d[NS];
			valid_q <= v_f;
		end
	end

	// entry stage takes magnitudes and quotient sign, then the divider stages follow
	always_ff @(posedge clk) begin
		if (en) begin
			dmag_d[0]  <= pop_data.dvs[DVS_W-1] ? dneg_w[DMAG_W-1:0]
			                                    : pop_data.dvs[DMAG_W-1:0];
			dv_d[0].rem <= '0;
			dv_d[0].nq  <= {mcmag_w, {SHIFT_MC{1'b0}}};
			neg_d[0]   <= coef.mc[COEF_W-1] ^ pop_data.dvs[DVS_W-1];
			x1_d[0]    <= pop_data.x1;
			zero_d[0]  <= pop_data.zero;
			for (int k = 0; k < NS; k++) begin
				dv_d[k+1]   <= div_steps(dv_d[k], dmag_d[k]);
				neg_d[k+1]  <= neg_d[k];
				x1_d[k+1]   <= x1_d[k];
				zero_d[k+1] <= zero_d[k];
			end
			for (int k = 0; k < NS - 1; k++) begin
				dmag_d[k+1] <= dmag_d[k];
			end
		end
	end

	assign sum_w = {{(SUM_W-X1_W){x1_f[X1_W-1]}}, x1_f}
	             + {x2_f[X2_W-1], x2_f}
	             + SUM_W'(ROUND_ADD);

	always_ff @(posedge clk) begin
		if (en) begin
			x2_f   <= neg_d[NS] ? -$signed({1'b0, dv_d[NS].nq})
			                    : $signed({1'b0, dv_d[NS].nq});
			x1_f   <= x1_d[NS];
			zero_f <= zero_d[NS];
			temp_q <= zero_f ? '0 : sum_w[SHIFT_OUT +: TEMP_W];
			dz_q   <= zero_f;
		end
	end

	assign result.valid       = valid_q;
	assign result.temp_tenths = temp_q;
	assign result.div_zero    = dz_q;

	a_pop_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |=> v_d[0])
		else $error("popped request lost at divider entry");

	a_zero_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && dz_q) |-> (temp_q == '0))
		else $error("zero divisor result not cleared");

endmodule

`default_nettype wire

/* hw/rtl/pressure_sensor_temp_compensation_core.sv */
// Top level of the temperature compensation core: coefficient registers,
// front end, queue and divider back end. Depends on pstc_pkg, pstc_ifs and all modules.
//
//  channel  | dir | payload                         | accepted when
//  ---------+-----+---------------------------------+----------------------------
//  sample   | in  | raw_temp[15:0]                  | sample.valid && sample.ready
//  result   | out | temp_tenths[23:0], div_zero     | result.valid && result.ready
//  cfg      | in  | index[3:0], data[15:0]          | cfg.valid && cfg.ready
//
// One sample per cycle sustained while result.ready holds. After its sample is accepted,
// a result passes through 16 registers: three front stages, one in the queue, the entry
// stage, nine divider stages of three quotient bits each, the sign fix and the output
// register. Reset clears only control state; coefficients reset to zero, no clearing
// pass. A stalled result holds the back end; the queue then fills and the front end
// drops sample.ready.
`default_nettype none

module pressure_sensor_temp_compensation_core
	import pstc_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pstc_sample_if.sink   sample,
	pstc_result_if.source result,
	pstc_cfg_if.sink      cfg
);

	coef_t  coef_q;
	logic   q_push_valid, q_push_ready;
	entry_t q_push_data;
	logic   q_pop_valid, q_pop_ready;
	entry_t q_pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_C5:  coef_q.c5 <= cfg.data;
				REG_C6:  coef_q.c6 <= cfg.data;
				REG_MC:  coef_q.mc <= cfg.data;
				REG_MD:  coef_q.md <= cfg.data;
				default: ;
			endcase
		end
	end

	pstc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef       (coef_q),
		.sample     (sample),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data)
	);

	pstc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	pstc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef_q),
		.pop_valid (q_pop_valid),
		.pop_ready (q_pop_ready),
		.pop_data  (q_pop_data),
		.result    (result)
	);

endmodule

`default_nettype wire
